[design/aoc_pkg.sv]
package aoc_pkg;

	// front rectangle size limit
	localparam int MAX_DIM    = 4096;

	localparam int COORD_W    = 12;
	localparam int OFS_W      = 14;
	localparam int DIM_W      = 13;
	localparam int CH_W       = 8;
	localparam int REL_W      = 15;   // coordinate minus offset, signed
	localparam int NAF_W      = 9;    // 256 - front alpha
	localparam int PROD_W     = 16;   // 8x8 products
	localparam int DEN_W      = 16;   // blend denominator, at most 255*257
	localparam int NUM_W      = 25;   // blend numerator
	localparam int NUM_CH     = 3;    // red, green, blue lanes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;
	localparam int IN_W       = 2 * COORD_W + 8 * CH_W;
	localparam int OUT_W      = 4 * CH_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_X     = 2'd0,
		CFG_OFFSET_Y     = 2'd1,
		CFG_FRONT_WIDTH  = 2'd2,
		CFG_FRONT_HEIGHT = 2'd3
	} cfg_idx_t;

	// one pixel, red in the lowest bits
	typedef struct packed {
		logic [CH_W-1:0] alpha;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgba_t;

	// input word, pixel_x in the lowest bits
	typedef struct packed {
		rgba_t              front;
		rgba_t              back;
		logic [COORD_W-1:0] pixel_y;
		logic [COORD_W-1:0] pixel_x;
	} in_word_t;

	// result of two restoring division steps
	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [1:0]       qbits;
	} dstep_t;

	// clamp front size to MAX_DIM
	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] res;
		res = v;
		if ((MAX_DIM < (1 << DIM_W)) && (v > DIM_W'(MAX_DIM)))
			res = DIM_W'(MAX_DIM);
		return res;
	endfunction

	// quotient bits hi and hi-1 of rem / den
	function automatic dstep_t div2(input logic [NUM_W-1:0] rem,
			input logic [DEN_W-1:0] den, input logic [2:0] hi);
		logic [NUM_W+7:0] r;
		logic [NUM_W+7:0] d;
		dstep_t           res;
		r = (NUM_W+8)'(rem);
		d = (NUM_W+8)'(den) << hi;
		res.qbits[1] = (r >= d);
		if (res.qbits[1])
			r = r - d;
		d = (NUM_W+8)'(den) << (hi - 3'd1);
		res.qbits[0] = (r >= d);
		if (res.qbits[0])
			r = r - d;
		res.rem = r[NUM_W-1:0];
		return res;
	endfunction

endpackage

[design/alpha_over_composite_unit.sv]
// Porter-Duff "over" compositing of a front RGBA pixel onto a back RGBA pixel.
// Input stream (s_axis): one word per back pixel, carrying its coordinates,
// the back pixel and the front pixel at that position. Output stream (m_axis):
// one word per input word, in order, with the composited pixel and a flag that
// tells whether the pixel lay inside the front rectangle.
// Configuration: cfg_wen/cfg_addr/cfg_wdata write offset_x, offset_y,
// front_width and front_height (indexes 0..3); write only while the block is
// empty. All four reset to 0, so nothing is covered until the size is set.
// Throughput: one pixel per clock when not stalled. Pipeline stages: coverage,
// products, sums, then a restoring divider resolving two quotient bits per
// stage over four stages, three colour lanes in parallel.
// Stall: the whole pipeline holds while the output word waits; s_axis_tready
// is high whenever the output register is empty or being taken, so bubbles
// ahead of a stall are not lost and no word is dropped or repeated.
// Reset (arst_n low) empties the pipeline and clears the configuration registers.
module alpha_over_composite_unit
	import aoc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pixel_x, pixel_y, back_red, back_green, back_blue, back_alpha,
	// front_red, front_green, front_blue, front_alpha
	input  logic [IN_W-1:0]       s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_red, out_green, out_blue, out_alpha
	output logic [OUT_W-1:0]      m_axis_tdata,
	// covered
	output logic                  m_axis_tuser
);

	logic [OFS_W-1:0] offset_x_q, offset_y_q;
	logic [DIM_W-1:0] front_width_q, front_height_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q     <= '0;
			offset_y_q     <= '0;
			front_width_q  <= '0;
			front_height_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_OFFSET_X:     offset_x_q     <= cfg_wdata;
				CFG_OFFSET_Y:     offset_y_q     <= cfg_wdata;
				CFG_FRONT_WIDTH:  front_width_q  <= cfg_wdata[DIM_W-1:0];
				CFG_FRONT_HEIGHT: front_height_q <= cfg_wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// global advance: pipeline moves when the output word is empty or taken
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	assign adv           = !vld_s7 || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// stage 1: coverage test
	in_word_t         in_w;
	logic [REL_W-1:0] rel_x, rel_y;
	logic             in_x, in_y;

	assign in_w  = in_word_t'(s_axis_tdata);
	assign rel_x = REL_W'(in_w.pixel_x) - REL_W'(signed'(offset_x_q));
	assign rel_y = REL_W'(in_w.pixel_y) - REL_W'(signed'(offset_y_q));
	assign in_x  = !rel_x[REL_W-1] &&
		(rel_x[REL_W-2:0] < (REL_W-1)'(sat_dim(front_width_q)));
	assign in_y  = !rel_y[REL_W-1] &&
		(rel_y[REL_W-2:0] < (REL_W-1)'(sat_dim(front_height_q)));

	logic             cov_s1;
	rgba_t            back_s1, front_s1;
	logic [NAF_W-1:0] naf_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cov_s1   <= in_x && in_y;
			back_s1  <= in_w.back;
			front_s1 <= in_w.front;
			naf_s1   <= NAF_W'(9'd256 - NAF_W'(in_w.front.alpha));
		end
	end

	// stage 2: first products
	logic                               cov_s2;
	rgba_t                              back_s2;
	logic [CH_W-1:0]                    fa_s2;
	logic [NAF_W-1:0]                   naf_s2;
	logic [PROD_W-1:0]                  wb_s2;
	logic [NUM_CH-1:0][PROD_W-1:0]      cfa_s2, cba_s2;
	logic [NUM_CH-1:0][CH_W-1:0]        cf1, cb1;

	assign cf1 = {front_s1.blue, front_s1.green, front_s1.red};
	assign cb1 = {back_s1.blue, back_s1.green, back_s1.red};

	always_ff @(posedge clk) begin
		if (adv) begin
			cov_s2  <= cov_s1;
			back_s2 <= back_s1;
			fa_s2   <= front_s1.alpha;
			naf_s2  <= naf_s1;
			wb_s2   <= PROD_W'(back_s1.alpha * naf_s1);
			for (int c = 0; c < NUM_CH; c++) begin
				cfa_s2[c] <= cf1[c] * front_s1.alpha;
				cba_s2[c] <= cb1[c] * back_s1.alpha;
			end
		end
	end

	// stage 3: denominator and numerators
	logic                         cov_s3;
	rgba_t                        back_s3;
	logic [DEN_W-1:0]             den_s3;
	logic [NUM_CH-1:0][NUM_W-1:0] num_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			cov_s3  <= cov_s2;
			back_s3 <= back_s2;
			den_s3  <= DEN_W'({fa_s2, 8'd0}) + wb_s2;
			for (int c = 0; c < NUM_CH; c++)
				num_s3[c] <= NUM_W'({cfa_s2[c], 8'd0}) +
					NUM_W'(cba_s2[c] * naf_s2);
		end
	end

	// stages 4..7: restoring division, two quotient bits per stage
	logic                         cov_s4, cov_s5, cov_s6, cov_s7;
	logic                         zero_s4, zero_s5, zero_s6, zero_s7;
	rgba_t                        back_s4, back_s5, back_s6, back_s7;
	logic [CH_W-1:0]              alpha_s4, alpha_s5, alpha_s6, alpha_s7;
	logic [DEN_W-1:0]             den_s4, den_s5, den_s6;
	logic [NUM_CH-1:0][NUM_W-1:0] rem_s4, rem_s5, rem_s6;
	logic [NUM_CH-1:0][1:0]       q_s4;
	logic [NUM_CH-1:0][3:0]       q_s5;
	logic [NUM_CH-1:0][5:0]       q_s6;
	logic [NUM_CH-1:0][7:0]       q_s7;
	dstep_t [NUM_CH-1:0]          d4, d5, d6, d7;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			d4[c] = div2(num_s3[c], den_s3, 3'd7);
			d5[c] = div2(rem_s4[c], den_s4, 3'd5);
			d6[c] = div2(rem_s5[c], den_s5, 3'd3);
			d7[c] = div2(rem_s6[c], den_s6, 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cov_s4   <= cov_s3;
			zero_s4  <= (den_s3 == '0);
			back_s4  <= back_s3;
			alpha_s4 <= den_s3[DEN_W-1:8];
			den_s4   <= den_s3;

			cov_s5   <= cov_s4;
			zero_s5  <= zero_s4;
			back_s5  <= back_s4;
			alpha_s5 <= alpha_s4;
			den_s5   <= den_s4;

			cov_s6   <= cov_s5;
			zero_s6  <= zero_s5;
			back_s6  <= back_s5;
			alpha_s6 <= alpha_s5;
			den_s6   <= den_s5;

			cov_s7   <= cov_s6;
			zero_s7  <= zero_s6;
			back_s7  <= back_s6;
			alpha_s7 <= alpha_s6;

			for (int c = 0; c < NUM_CH; c++) begin
				rem_s4[c] <= d4[c].rem;
				q_s4[c]   <= d4[c].qbits;
				rem_s5[c] <= d5[c].rem;
				q_s5[c]   <= {q_s4[c], d5[c].qbits};
				rem_s6[c] <= d6[c].rem;
				q_s6[c]   <= {q_s5[c], d6[c].qbits};
				q_s7[c]   <= {q_s6[c], d7[c].qbits};
			end
		end
	end

	// output select: blend, zero-weight blend, or back pixel pass-through
	rgba_t out_px;

	always_comb begin
		if (!cov_s7) begin
			out_px = back_s7;
		end else begin
			out_px.alpha = alpha_s7;
			out_px.red   = zero_s7 ? '0 : q_s7[0];
			out_px.green = zero_s7 ? '0 : q_s7[1];
			out_px.blue  = zero_s7 ? '0 : q_s7[2];
		end
	end

	assign m_axis_tvalid = vld_s7;
	assign m_axis_tdata  = out_px;
	assign m_axis_tuser  = cov_s7;

	// a zero denominator only arises with both weights zero
	a_zero_den_zero_num: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && (den_s3 == '0) |->
			(num_s3[0] == '0) && (num_s3[1] == '0) && (num_s3[2] == '0))
		else $error("blend numerator nonzero with zero denominator");

	// every quotient fits in eight bits, so the divider has enough stages
	a_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && (den_s3 != '0) |->
			(num_s3[0] < NUM_W'({den_s3, 8'd0})) &&
			(num_s3[1] < NUM_W'({den_s3, 8'd0})) &&
			(num_s3[2] < NUM_W'({den_s3, 8'd0})))
		else $error("blend quotient exceeds eight bits");

	// a stall freezes the occupancy of every stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7}))
		else $error("pipeline occupancy changed during stall");

endmodule
